@@ hdl/egp_pkg.sv @@
// egp_pkg: shared types and constants for the electrostatic grid potential block
// item structs passed along the square-root and divider cell chains
// no dependencies
`timescale 1ns / 1ps

package egp_pkg;

  // datapath widths fixed by the coordinate formats
  localparam int MAG_W  = 44;   // magnitude of one axis distance, Q28.16
  localparam int RAD_W  = 88;   // squared distance, Q56.32
  localparam int ROOT_W = 44;   // floor square root, Q28.16
  localparam int QUO_W  = 32;   // reciprocal quotient bits, Q.30

  // register indexes of the configuration port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_GRID_SPACING = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HALF_X       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_Y       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HALF_Z       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ATOM_COUNT   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIST_DEP     = 3'd5;

  // item kinds carried in tuser
  localparam logic [1:0] MODE_LOAD_ATOM = 2'd0;
  localparam logic [1:0] MODE_LOAD_EPS  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE   = 2'd2;

  // remainder left after the quotient bits above bit 31 of 2^46 / r
  localparam logic [ROOT_W-1:0] DIV_SEED     = 44'd16384;
  // below this radius the reciprocal is capped at 2.0
  localparam logic [ROOT_W-1:0] ROOT_CAP_MIN = 44'd32768;
  localparam logic [QUO_W-1:0]  INV_CAP      = 32'h8000_0000;

  // one atom in flight through the square-root cells
  typedef struct packed {
    logic              valid;
    logic [RAD_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [31:0]       w;
  } sqrt_item_t;

  // one atom in flight through the divider cells
  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic [31:0]       w;
  } div_item_t;

endpackage

@@ hdl/egp_sqrt_cell.sv @@
// egp_sqrt_cell: one bit of a digit-by-digit floor square root
// keeps rem = radicand - root^2 while deciding one root bit; uses egp_pkg
`timescale 1ns / 1ps

module egp_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  egp_pkg::sqrt_item_t    din,
  output egp_pkg::sqrt_item_t    dout
);
  import egp_pkg::*;

  logic [RAD_W+1:0] trial;
  logic             take;

  // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
  assign trial = ({{(RAD_W+2-ROOT_W){1'b0}}, din.root} << (BIT + 1))
               | ((RAD_W+2)'(1) << (2 * BIT));
  assign take  = trial <= {2'b00, din.rem};

  // pass the item on with one more root bit settled
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.rem  <= take ? (din.rem - trial[RAD_W-1:0]) : din.rem;
    dout.root <= take ? (din.root | (ROOT_W'(1) << BIT)) : din.root;
    dout.w    <= din.w;
  end

endmodule

@@ hdl/egp_div_cell.sv @@
// egp_div_cell: one quotient bit of the restoring division 2^46 / r
// the dividend has no set bits below bit 46, so a zero is shifted in; uses egp_pkg
`timescale 1ns / 1ps

module egp_div_cell #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  egp_pkg::div_item_t   din,
  output egp_pkg::div_item_t   dout
);
  import egp_pkg::*;

  logic [ROOT_W:0] shifted;
  logic [ROOT_W:0] diff;
  logic            take;

  // shift the partial remainder and try the subtraction
  assign shifted = {din.rem, 1'b0};
  assign diff    = shifted - {1'b0, din.r};
  assign take    = shifted >= {1'b0, din.r};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.r   <= din.r;
    dout.rem <= take ? diff[ROOT_W-1:0] : shifted[ROOT_W-1:0];
    dout.quo <= take ? (din.quo | (QUO_W'(1) << BIT)) : din.quo;
    dout.w   <= din.w;
  end

endmodule

@@ hdl/electrostatic_grid_potential.sv @@
// electrostatic_grid_potential: Coulomb potential at one grid point per compute item
// top level: atom and dielectric stores, distance front end, sqrt and divider
// cell chains, term scaling and accumulator; uses egp_pkg, egp_sqrt_cell, egp_div_cell
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: tuser carries the item kind (load atom, load dielectric
//   entry, compute). Load items are written into the atom store or the
//   dielectric table and give no result. A compute item gives one
//   result on m_* with the energy in thousandths.
//   Configuration is to be written through cfg_we / cfg_index / cfg_data
//   only while idle; the block itself does not enforce this. A compute item
//   streams the atoms in slots 0 to atom_count - 1 (at most MAX_ATOMS), one
//   per cycle, from the atom store through a row of 44 square-root cells and
//   32 divider cells.
//   Only one compute item is in work at a time; s_tready is low meanwhile.
//   A result waiting on m_* does not hold off new items; a finished sum waits
//   for the output register only if the previous result is still untaken.
//   Reset clears control state and the registers to their defaults. The atom
//   store and the table are not cleared; entries read must have been written.
module electrostatic_grid_potential #(
  parameter int MAX_ATOMS          = 4096,
  parameter int TABLE_DEPTH        = 16384,
  parameter int STEPS_PER_ANGSTROM = 100
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot, pos_x, pos_y, pos_z, load_value, grid_x, grid_y, grid_z, prior_energy
  input  logic [223:0] s_tdata,
  // mode
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // energy_milli
  output logic [47:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [egp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);
  import egp_pkg::*;

  localparam int AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int CW  = 17;
  localparam logic [9:0] STEPS = 10'(STEPS_PER_ANGSTROM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // input fields
  logic [13:0] in_slot;
  logic [31:0] in_pos_x, in_pos_y, in_pos_z, in_load_value;
  logic [9:0]  in_grid_x, in_grid_y, in_grid_z;
  logic [47:0] in_prior_energy;

  assign in_slot         = s_tdata[13:0];
  assign in_pos_x        = s_tdata[45:14];
  assign in_pos_y        = s_tdata[77:46];
  assign in_pos_z        = s_tdata[109:78];
  assign in_load_value   = s_tdata[141:110];
  assign in_grid_x       = s_tdata[151:142];
  assign in_grid_y       = s_tdata[161:152];
  assign in_grid_z       = s_tdata[171:162];
  assign in_prior_energy = s_tdata[219:172];

  // configuration registers
  logic [31:0] grid_spacing;
  logic [9:0]  half_count_x, half_count_y, half_count_z;
  logic [12:0] atom_count;
  logic        dist_dep_dielectric;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_spacing        <= 32'd24576;
      half_count_x        <= '0;
      half_count_y        <= '0;
      half_count_z        <= '0;
      atom_count          <= '0;
      dist_dep_dielectric <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SPACING: grid_spacing        <= cfg_data;
        REG_HALF_X:       half_count_x        <= cfg_data[9:0];
        REG_HALF_Y:       half_count_y        <= cfg_data[9:0];
        REG_HALF_Z:       half_count_z        <= cfg_data[9:0];
        REG_ATOM_COUNT:   atom_count          <= cfg_data[12:0];
        REG_DIST_DEP:     dist_dep_dielectric <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control
  logic [1:0]    state;
  logic [CW-1:0] cnt, n_atoms;
  logic          in_acc, issue, pipe_busy, out_free;
  logic          atom_wr, eps_wr, start;

  assign s_tready = state == ST_IDLE;
  assign in_acc   = s_tvalid && s_tready;
  assign issue    = (state == ST_RUN) && (cnt < n_atoms);
  assign out_free = !m_tvalid || m_tready;
  assign atom_wr  = in_acc && s_tuser == MODE_LOAD_ATOM
                 && ({3'b000, in_slot} < CW'(MAX_ATOMS));
  assign eps_wr   = in_acc && s_tuser == MODE_LOAD_EPS
                 && ({3'b000, in_slot} < CW'(TABLE_DEPTH));
  assign start    = in_acc && s_tuser == MODE_COMPUTE;

  // grid point position per axis: (index - centre) * spacing
  logic signed [10:0] dgx, dgy, dgz;
  logic signed [43:0] gpx_n, gpy_n, gpz_n;
  logic signed [43:0] gp [0:2];

  assign dgx   = $signed({1'b0, in_grid_x}) - $signed({1'b0, half_count_x});
  assign dgy   = $signed({1'b0, in_grid_y}) - $signed({1'b0, half_count_y});
  assign dgz   = $signed({1'b0, in_grid_z}) - $signed({1'b0, half_count_z});
  assign gpx_n = 44'(dgx * $signed({1'b0, grid_spacing}));
  assign gpy_n = 44'(dgy * $signed({1'b0, grid_spacing}));
  assign gpz_n = 44'(dgz * $signed({1'b0, grid_spacing}));

  // accumulator
  logic signed [63:0] acc, acc_next;
  logic signed [63:0] term4;
  logic               t4_v;
  logic [64:0]        acc_sum;

  assign acc_sum = {acc[63], acc} + {term4[63], term4};
  always_comb begin
    if (acc_sum[64] != acc_sum[63]) begin
      acc_next = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_next = acc_sum[63:0];
    end
  end

  // rounding to thousandths
  logic signed [47:0] q_milli;
  logic [41:0]        f_milli;
  logic [42:0]        f_round;
  logic [47:0]        energy_milli;

  assign q_milli      = $signed({{16{acc[63]}}, acc[63:32]}) * 48'sd1000;
  assign f_milli      = 42'(acc[31:0]) * 42'd1000;
  assign f_round      = {1'b0, f_milli} + 43'h0_8000_0000;
  assign energy_milli = q_milli + 48'(f_round[42:32]);

  // sequencer, counters and grid point latch
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            cnt <= cnt + CW'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    if (start) begin
      gp[0]   <= gpx_n;
      gp[1]   <= gpy_n;
      gp[2]   <= gpz_n;
      n_atoms <= ({4'b0000, atom_count} > CW'(MAX_ATOMS)) ? CW'(MAX_ATOMS)
                                                          : {4'b0000, atom_count};
    end
  end

  // accumulator: prior energy moved to Q32.32, then saturating sums
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= {in_prior_energy, 16'd0};
    end else if (t4_v) begin
      acc <= acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ST_FIN && out_free) begin
      m_tdata <= energy_milli;
    end
  end

  // atom store: x, y, z, w from the low bits up
  logic [127:0] atom_store [0:MAX_ATOMS-1];
  logic [127:0] atom_rd;
  logic         s1_v;

  always_ff @(posedge clk) begin
    if (atom_wr) begin
      atom_store[AW'(in_slot)] <= {in_load_value, in_pos_z, in_pos_y, in_pos_x};
    end
    atom_rd <= atom_store[AW'(cnt)];
  end

  // stage 1: axis distance magnitudes
  logic signed [44:0] diff1 [0:2];
  logic [MAG_W-1:0]   mag1  [0:2];
  logic [MAG_W-1:0]   mag2  [0:2];
  logic [31:0]        w2;
  logic               s2_v;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff1[a] = $signed({{13{atom_rd[32*a+31]}}, atom_rd[32*a +: 32]})
               - $signed({gp[a][43], gp[a]});
      mag1[a]  = diff1[a][44] ? 44'(-diff1[a]) : diff1[a][43:0];
    end
  end

  // stage 2: partial products of each square, 22-bit halves
  logic [43:0] hh3 [0:2];
  logic [43:0] hl3 [0:2];
  logic [43:0] ll3 [0:2];
  logic [31:0] w3;
  logic        s3_v;

  // stage 3: per-axis squares
  logic [RAD_W-1:0] sq4 [0:2];
  logic [31:0]      w4;
  logic             s4_v;

  sqrt_item_t sq_link [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v             <= 1'b0;
      s2_v             <= 1'b0;
      s3_v             <= 1'b0;
      s4_v             <= 1'b0;
      sq_link[0].valid <= 1'b0;
    end else begin
      s1_v             <= issue;
      s2_v             <= s1_v;
      s3_v             <= s2_v;
      s4_v             <= s3_v;
      sq_link[0].valid <= s4_v;
    end
    for (int a = 0; a < 3; a++) begin
      mag2[a] <= mag1[a];
      hh3[a]  <= mag2[a][43:22] * mag2[a][43:22];
      hl3[a]  <= mag2[a][43:22] * mag2[a][21:0];
      ll3[a]  <= mag2[a][21:0] * mag2[a][21:0];
      sq4[a]  <= {hh3[a], 44'd0} + (RAD_W'(hl3[a]) << 23) + RAD_W'(ll3[a]);
    end
    w2 <= atom_rd[127:96];
    w3 <= w2;
    w4 <= w3;
    // stage 4: squared distance enters the root chain
    sq_link[0].rem  <= sq4[0] + sq4[1] + sq4[2];
    sq_link[0].root <= '0;
    sq_link[0].w    <= w4;
  end

  // square-root cells, most significant root bit first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    egp_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (sq_link[k]),
      .dout (sq_link[k+1])
    );
  end

  // divider cells for 2^46 / r
  div_item_t dv_link [0:QUO_W];

  always_comb begin
    dv_link[0].valid = sq_link[ROOT_W].valid;
    dv_link[0].r     = sq_link[ROOT_W].root;
    dv_link[0].rem   = DIV_SEED;
    dv_link[0].quo   = '0;
    dv_link[0].w     = sq_link[ROOT_W].w;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    egp_div_cell #(.BIT(QUO_W - 1 - k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (dv_link[k]),
      .dout (dv_link[k+1])
    );
  end

  // term stage 1: capped reciprocal, weight product, table index
  div_item_t          dq;
  logic [QUO_W-1:0]   inv;
  logic signed [64:0] p_full;
  logic [53:0]        idx_prod;
  logic [37:0]        idx_raw;
  logic [TAW-1:0]     eps_addr;

  assign dq       = dv_link[QUO_W];
  assign inv      = (dq.r < ROOT_CAP_MIN) ? INV_CAP : dq.quo;
  assign p_full   = $signed(dq.w) * $signed({1'b0, inv});
  assign idx_prod = dq.r * STEPS;
  assign idx_raw  = idx_prod[53:16];
  assign eps_addr = (idx_raw > 38'(TABLE_DEPTH - 1)) ? TAW'(TABLE_DEPTH - 1)
                                                      : TAW'(idx_raw);

  logic [31:0]        dielectric_table [0:TABLE_DEPTH-1];
  logic signed [31:0] eps2;
  logic signed [63:0] p2;
  logic               t2_v;

  always_ff @(posedge clk) begin
    if (eps_wr) begin
      dielectric_table[TAW'(in_slot)] <= in_load_value;
    end
    eps2 <= dielectric_table[eps_addr];
    p2   <= p_full[63:0];
  end

  // term stage 2: split the dielectric product into two halves
  logic signed [64:0] ph_prod;
  logic signed [63:0] pl_prod;
  logic signed [64:0] ph3;
  logic signed [63:0] pl3, plain3;
  logic               t3_v;

  assign ph_prod = $signed(p2[63:31]) * eps2;
  assign pl_prod = $signed({1'b0, p2[30:0]}) * eps2;

  always_ff @(posedge clk) begin
    ph3    <= ph_prod;
    pl3    <= pl_prod;
    plain3 <= p2 >>> 14;
  end

  // term stage 3: recombine, floor shift by 30, saturate to 64 bits
  logic signed [96:0] full3;
  logic signed [66:0] sh3;
  logic signed [63:0] diel3;

  assign full3 = ($signed({{32{ph3[64]}}, ph3}) <<< 31) + $signed({{33{pl3[63]}}, pl3});
  assign sh3   = full3[96:30];
  always_comb begin
    if (sh3[66:63] == 4'b0000 || sh3[66:63] == 4'b1111) begin
      diel3 = sh3[63:0];
    end else begin
      diel3 = sh3[66] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_v <= 1'b0;
      t3_v <= 1'b0;
      t4_v <= 1'b0;
    end else begin
      t2_v <= dq.valid;
      t3_v <= t2_v;
      t4_v <= t3_v;
    end
    term4 <= dist_dep_dielectric ? diel3 : plain3;
  end

  // any atom still in flight
  always_comb begin
    pipe_busy = s1_v | s2_v | s3_v | s4_v | sq_link[0].valid | t2_v | t3_v | t4_v;
    for (int k = 1; k <= ROOT_W; k++) begin
      pipe_busy = pipe_busy | sq_link[k].valid;
    end
    for (int k = 1; k <= QUO_W; k++) begin
      pipe_busy = pipe_busy | dv_link[k].valid;
    end
  end

endmodule

@@ hdl/egp_checker.sv @@
// egp_checker: port-level checks for electrostatic_grid_potential
// watches the stream handshakes only; uses egp_pkg, bound to the top level
`timescale 1ns / 1ps

module egp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready
);
  import egp_pkg::*;

  // a result held back by the receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // a load item never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != MODE_COMPUTE && !m_tvalid |=> !m_tvalid)
    else $error("load item gave a result");

  // a compute item occupies the block for at least the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == MODE_COMPUTE |=> !s_tready)
    else $error("new item taken during compute");

endmodule

bind electrostatic_grid_potential egp_checker u_egp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

@@ dv/electrostatic_grid_potential_checker.sv @@
// electrostatic_grid_potential_checker: watches the load, compute, result and register channels
// keeps its own atom store, dielectric table and register copies, predicts and compares each energy
// depends on egp_pkg
`timescale 1ns / 1ps

module electrostatic_grid_potential_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // slot, pos_x, pos_y, pos_z, load_value, grid_x, grid_y, grid_z, prior_energy
  input  logic [223:0] s_tdata,
  // mode
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // energy_milli
  input  logic [47:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [egp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data,
  output int           failures,
  output int           pending
);
  import egp_pkg::*;

  localparam int ATOM_SLOTS = 4096;
  localparam int EPS_DEPTH  = 16384;
  localparam logic [63:0] RECIP_CAP = 64'h8000_0000;

  // mirrored state
  logic signed [31:0] atom_x [ATOM_SLOTS];
  logic signed [31:0] atom_y [ATOM_SLOTS];
  logic signed [31:0] atom_z [ATOM_SLOTS];
  logic signed [31:0] atom_w [ATOM_SLOTS];
  logic signed [31:0] eps_table [EPS_DEPTH];
  logic [31:0] spacing;
  logic [9:0]  half_x, half_y, half_z;
  logic [12:0] atoms_used;
  logic        dist_dep;

  logic [47:0] energy_due [$];

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // floor square root of a Q96.32 squared distance, Q48.16 result
  function automatic logic [63:0] floor_root(logic [127:0] sq);
    logic [63:0] res;
    logic [63:0] c;
    res = 0;
    for (int b = 46; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= sq) res = c;
    end
    return res;
  endfunction

  // energy at one grid point in thousandths
  function automatic logic [47:0] grid_energy(logic [9:0] gxi, logic [9:0] gyi,
                                              logic [9:0] gzi, logic [47:0] prior);
    longint gx, gy, gz, acc, term, p, q;
    logic [63:0] dx, dy, dz, r, recip, idx, f;
    logic [127:0] sq;
    logic signed [127:0] wide, qw;
    logic signed [31:0] e;
    logic [64:0] sum;
    int n;
    gx = (longint'(gxi) - longint'(half_x)) * longint'(spacing);
    gy = (longint'(gyi) - longint'(half_y)) * longint'(spacing);
    gz = (longint'(gzi) - longint'(half_z)) * longint'(spacing);
    acc = longint'($signed(prior)) * 65536;
    n = (atoms_used > ATOM_SLOTS) ? ATOM_SLOTS : int'(atoms_used);
    for (int i = 0; i < n; i++) begin
      dx = magnitude(longint'(atom_x[i]) - gx);
      dy = magnitude(longint'(atom_y[i]) - gy);
      dz = magnitude(longint'(atom_z[i]) - gz);
      sq = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy} + {64'd0, dz} * {64'd0, dz};
      r = floor_root(sq);
      recip = (r == 0) ? RECIP_CAP : (64'd1 << 46) / r;
      if (recip > RECIP_CAP) recip = RECIP_CAP;
      p = longint'(atom_w[i]) * longint'(recip);
      if (dist_dep) begin
        idx = (r * 100) >> 16;
        if (idx > EPS_DEPTH - 1) idx = EPS_DEPTH - 1;
        e = eps_table[idx];
        wide = $signed({{64{p[63]}}, p}) * $signed({{96{e[31]}}, e});
        qw = wide >>> 30;
        // saturate the scaled term to 64 bits
        if (&qw[127:63] || ~|qw[127:63]) term = qw[63:0];
        else term = qw[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        term = p >>> 14;
      end
      sum = {acc[63], acc} + {term[63], term};
      if (sum[64] != sum[63]) acc = sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      else acc = sum[63:0];
    end
    // round half up to thousandths
    q = acc >>> 32;
    f = {32'd0, acc[31:0]};
    q = q * 1000 + longint'((f * 1000 + 64'h8000_0000) >> 32);
    return q[47:0];
  endfunction

  task automatic report_mismatch(string what, logic [47:0] want, logic [47:0] got);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what,
             $signed(want), $signed(got));
    failures++;
  endtask

  initial begin
    failures = 0;
    pending  = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      spacing    <= 32'd24576;
      half_x     <= 0;
      half_y     <= 0;
      half_z     <= 0;
      atoms_used <= 0;
      dist_dep   <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_SPACING: spacing    <= cfg_data;
          REG_HALF_X:       half_x     <= cfg_data[9:0];
          REG_HALF_Y:       half_y     <= cfg_data[9:0];
          REG_HALF_Z:       half_z     <= cfg_data[9:0];
          REG_ATOM_COUNT:   atoms_used <= cfg_data[12:0];
          REG_DIST_DEP:     dist_dep   <= cfg_data[0];
          default: ;
        endcase
      end
      // accepted input item
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          MODE_LOAD_ATOM:
            if (s_tdata[13:0] < ATOM_SLOTS) begin
              atom_x[s_tdata[11:0]] <= s_tdata[45:14];
              atom_y[s_tdata[11:0]] <= s_tdata[77:46];
              atom_z[s_tdata[11:0]] <= s_tdata[109:78];
              atom_w[s_tdata[11:0]] <= s_tdata[141:110];
            end
          MODE_LOAD_EPS: eps_table[s_tdata[13:0]] <= s_tdata[141:110];
          MODE_COMPUTE:
            energy_due.push_back(grid_energy(s_tdata[151:142], s_tdata[161:152],
                                             s_tdata[171:162], s_tdata[219:172]));
          default: ;
        endcase
      end
      // accepted result item
      if (m_tvalid && m_tready) begin
        if (energy_due.size() == 0) begin
          report_mismatch("unexpected energy_milli", 48'd0, m_tdata);
        end else begin
          if (energy_due[0] !== m_tdata)
            report_mismatch("energy_milli", energy_due[0], m_tdata);
          void'(energy_due.pop_front());
        end
      end
      pending = energy_due.size();
    end
  end

endmodule

@@ dv/electrostatic_grid_potential_tb.sv @@
// electrostatic_grid_potential_tb: stimulus, clock, reset and verdict for the grid potential block
// directed and random load / compute items over several register settings
// depends on egp_pkg, electrostatic_grid_potential, electrostatic_grid_potential_checker
`timescale 1ns / 1ps

module electrostatic_grid_potential_tb;
  import egp_pkg::*;

  localparam int IDLE_LIMIT = 30000;

  // where random atom coordinates are drawn from
  localparam int POS_ANY  = 0;
  localparam int POS_NEAR = 1;
  localparam int POS_FAR  = 2;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [223:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [47:0]  m_tdata;
  logic         cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [31:0]  cfg_data;
  int           failures;
  int           pending;
  int           burst_left;
  int           idle_cycles;
  int           rx_left;
  int           rx_style;
  int           pos_style;

  electrostatic_grid_potential dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  electrostatic_grid_potential_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // receiver: ready, coin toss or mostly stalled, switching style at random times
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_left  = $urandom_range(16, 80);
    end else begin
      rx_left--;
    end
    case (rx_style)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL electrostatic_grid_potential");
      $finish;
    end
  end

  function automatic logic [223:0] pack_item(logic [13:0] slot, logic [31:0] px,
      logic [31:0] py, logic [31:0] pz, logic [31:0] value, logic [9:0] gx,
      logic [9:0] gy, logic [9:0] gz, logic [47:0] prior);
    return {4'd0, prior, gz, gy, gx, value, pz, py, px, slot};
  endfunction

  // coordinate: anywhere, within 0.1 angstrom of the origin, or beyond 28672 angstrom
  function automatic logic [31:0] rand_pos();
    logic [31:0] v;
    case (pos_style)
      POS_NEAR: return 32'($urandom_range(0, 13108)) - 32'd6554;
      POS_FAR: begin
        v = $urandom_range(32'h7000_0000, 32'h7FFF_FFFF);
        return ($urandom_range(0, 1) == 0) ? v : -v;
      end
      default: begin
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, 60 * 65536) - 30 * 65536;
      end
    endcase
  endfunction

  // weight or dielectric factor: mostly within +-2.0
  function automatic logic [31:0] rand_factor();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 4 * 65536) - 2 * 65536;
  endfunction

  function automatic logic [47:0] rand_prior();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) return v[47:0];
    return 48'($signed(v[31:0]) >>> 8);
  endfunction

  task automatic send_item(logic [1:0] kind, logic [223:0] data);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    s_tuser  <= kind;
    s_tdata  <= data;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic load_atom(logic [13:0] slot, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [31:0] w);
    send_item(MODE_LOAD_ATOM, pack_item(slot, px, py, pz, w, 0, 0, 0, 0));
  endtask

  task automatic compute_at(logic [9:0] gx, logic [9:0] gy, logic [9:0] gz,
                            logic [47:0] prior);
    send_item(MODE_COMPUTE, pack_item(14'($urandom), $urandom, $urandom, $urandom,
                                      $urandom, gx, gy, gz, prior));
  endtask

  // rewrite the atoms that are summed, with the current coordinate spread
  task automatic reload_atoms(int count);
    for (int i = 0; i < count; i++)
      load_atom(14'(i), rand_pos(), rand_pos(), rand_pos(), rand_factor());
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // drain all results and let the block settle before touching registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_registers(logic [31:0] sp, logic [9:0] hx, logic [9:0] hy,
                               logic [9:0] hz, logic [12:0] count, logic dd);
    wait_idle();
    write_reg(REG_GRID_SPACING, sp);
    write_reg(REG_HALF_X, 32'(hx));
    write_reg(REG_HALF_Y, 32'(hy));
    write_reg(REG_HALF_Z, 32'(hz));
    write_reg(REG_ATOM_COUNT, 32'(count));
    write_reg(REG_DIST_DEP, 32'(dd));
  endtask

  // random mix of computes, atom and table loads, and unused-mode noise
  task automatic random_items(int total, int compute_pct);
    int pick;
    logic [13:0] slot;
    for (int i = 0; i < total; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < compute_pct) begin
        compute_at(10'($urandom), 10'($urandom), 10'($urandom), rand_prior());
      end else if (pick < compute_pct + 30) begin
        slot = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 4095));
        load_atom(slot, rand_pos(), rand_pos(), rand_pos(), rand_factor());
      end else if (pick < 95) begin
        send_item(MODE_LOAD_EPS, pack_item(14'($urandom), 0, 0, 0, rand_factor(),
                                           0, 0, 0, 0));
      end else begin
        send_item(2'd3, pack_item(14'($urandom), $urandom, $urandom, $urandom, $urandom,
                                  10'($urandom), 10'($urandom), 10'($urandom),
                                  rand_prior()));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = MODE_LOAD_ATOM;
    m_tready   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_GRID_SPACING;
    cfg_data   = '0;
    burst_left = 0;
    idle_cycles = 0;
    rx_left    = 0;
    rx_style   = 0;
    pos_style  = POS_ANY;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no atoms summed: prior energy extremes, rounding only
    compute_at(0, 0, 0, 48'd0);
    compute_at(10'd1023, 10'd1023, 10'd1023, 48'h7FFF_FFFF_FFFF);
    compute_at(0, 10'd1023, 0, 48'h8000_0000_0000);
    compute_at(10'd512, 0, 10'd1023, 48'hFFFF_FFFF_FFFF);
    compute_at(0, 0, 0, 48'd1);

    // table entries reachable from atoms near a grid point, and the clamped last entry
    for (int i = 0; i < 24; i++)
      send_item(MODE_LOAD_EPS, pack_item(14'(i), 0, 0, 0, rand_factor(), 0, 0, 0, 0));
    send_item(MODE_LOAD_EPS, pack_item(14'd16383, 0, 0, 0, rand_factor(), 0, 0, 0, 0));

    // one atom: zero distance cap, weight and position extremes, ignored items
    set_registers(32'd24576, 0, 0, 0, 13'd1, 1'b0);
    load_atom(0, 0, 0, 0, 32'h0001_0000);
    compute_at(0, 0, 0, 48'd0);
    compute_at(1, 0, 0, 48'd0);
    load_atom(0, 0, 0, 0, 32'h7FFF_FFFF);
    compute_at(0, 0, 0, 48'h7FFF_FFFF_FFFF);
    load_atom(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    compute_at(10'd1023, 10'd1023, 10'd1023, 48'h8000_0000_0000);
    load_atom(14'd4096, 0, 0, 0, 32'h0001_0000);
    load_atom(14'd16383, 0, 0, 0, 32'h0001_0000);
    send_item(2'd3, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(MODE_LOAD_EPS, pack_item(14'd16383, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
    compute_at(0, 0, 0, 48'd12345);
    random_items(16, 40);

    // near atoms and the finest spacing with dielectric scaling
    set_registers(32'd1, 10'd1023, 10'd1023, 10'd1023, 13'd8, 1'b1);
    pos_style = POS_NEAR;
    reload_atoms(8);
    random_items(12, 40);
    // coarsest spacing, plain mode
    set_registers(32'hFFFF_FFFF, 10'd512, 10'd512, 10'd512, 13'd8, 1'b0);
    pos_style = POS_ANY;
    random_items(12, 40);
    // zero spacing puts every point at the origin
    set_registers(32'd0, 10'($urandom), 10'($urandom), 10'($urandom), 13'd8, 1'b1);
    pos_style = POS_NEAR;
    reload_atoms(8);
    random_items(10, 40);
    // distant atoms index past the table and read the last entry
    set_registers(32'd65536, 10'd10, 10'd10, 10'd10, 13'd8, 1'b1);
    pos_style = POS_FAR;
    reload_atoms(8);
    random_items(10, 40);
    // any spacing and centre, plain mode
    set_registers($urandom, 10'($urandom), 10'($urandom), 10'($urandom),
                  13'($urandom_range(1, 8)), 1'b0);
    pos_style = POS_ANY;
    random_items(10, 40);

    wait_idle();
    if (failures == 0) $display("PASS electrostatic_grid_potential");
    else $display("FAIL electrostatic_grid_potential");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/egp_pkg.sv
hdl/egp_sqrt_cell.sv
hdl/egp_div_cell.sv
hdl/electrostatic_grid_potential.sv
hdl/egp_checker.sv
dv/electrostatic_grid_potential_checker.sv
dv/electrostatic_grid_potential_tb.sv
